@@ design/ddoa_pkg.sv @@
// ddoa_pkg: widths, calendar tables and microcode ROM of the date/day offset adder.
// No dependencies. Imported by the channel interfaces, the top level, the checker and the testbench.
`default_nettype none

package ddoa_pkg;

   // Field widths
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int OFFSET_BITS = 20;
   localparam int RES_YEAR_W = 15;
   localparam int DOY_W      = 9;

   // Serial day numbers (sum of two dates stays below 2^23, 365*year below 2^24)
   localparam int SER_W      = 24;

   // floor(x / 100) for 15-bit x as (x * 5243) >> 19
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = RES_YEAR_W + RECIP_W;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int HUND_W      = QUO_W + 7;
   localparam logic [HUND_W-1:0] CENTURY = 16'd100;

   // Calendar constants
   localparam logic [YEAR_W-1:0]  YEAR_LIMIT    = 14'd9999;
   localparam logic [SER_W-1:0]   DAYS_PER_YEAR = 24'd365;
   localparam int                 MONTHS        = 12;
   localparam logic [MONTH_W-1:0] FEB           = 4'd1;
   localparam logic [DAY_W-1:0]   LAST_DAY      = 5'd31;
   localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd12;

   // Sequencer
   localparam int PC_W  = 5;
   localparam int BIT_W = 4;
   localparam int UOP_W = 4;
   localparam int COND_W = 3;

   // Datapath operations
   localparam logic [UOP_W-1:0] U_MQY    = 4'd0;  // q = yop / 100
   localparam logic [UOP_W-1:0] U_MQN    = 4'd1;  // q = (yop - 1) / 100
   localparam logic [UOP_W-1:0] U_LEAP   = 4'd2;  // leap flag of yop
   localparam logic [UOP_W-1:0] U_DBY    = 4'd3;  // days before year yop
   localparam logic [UOP_W-1:0] U_ACC1   = 4'd4;  // num = serial of first date
   localparam logic [UOP_W-1:0] U_LDY2   = 4'd5;  // yop = second year
   localparam logic [UOP_W-1:0] U_ACC2   = 4'd6;  // num += serial of second date
   localparam logic [UOP_W-1:0] U_ADDOFF = 4'd7;  // num += offset
   localparam logic [UOP_W-1:0] U_SINIT  = 4'd8;  // start year search
   localparam logic [UOP_W-1:0] U_SCMP   = 4'd9;  // one year search bit
   localparam logic [UOP_W-1:0] U_REM    = 4'd10; // day within result year
   localparam logic [UOP_W-1:0] U_WALK   = 4'd11; // one month step
   localparam logic [UOP_W-1:0] U_DONE   = 4'd12; // load result register
   localparam logic [UOP_W-1:0] U_ZERO   = 4'd13; // zero serial result

   // Jump conditions
   localparam logic [COND_W-1:0] C_NONE   = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
   localparam logic [COND_W-1:0] C_OP0    = 3'd2;
   localparam logic [COND_W-1:0] C_ZERO   = 3'd3;
   localparam logic [COND_W-1:0] C_BIT    = 3'd4;
   localparam logic [COND_W-1:0] C_WALK   = 3'd5;

   // Jump targets
   localparam logic [PC_W-1:0] A_ADDOFF = 5'd11;
   localparam logic [PC_W-1:0] A_SINIT  = 5'd12;
   localparam logic [PC_W-1:0] A_SLOOP  = 5'd13;
   localparam logic [PC_W-1:0] A_WALK   = 5'd21;
   localparam logic [PC_W-1:0] A_ZERO   = 5'd23;

   typedef struct packed {
      logic [UOP_W-1:0]  uop;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
      logic              last;
   } uword_type;

   function automatic uword_type mk_uword(input logic [UOP_W-1:0] uop,
                                          input logic [COND_W-1:0] cond,
                                          input logic [PC_W-1:0] target,
                                          input logic last);
      uword_type w;
      w.uop    = uop;
      w.cond   = cond;
      w.target = target;
      w.last   = last;
      return w;
   endfunction

   // Microprogram
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         5'd0:    w = mk_uword(U_MQY,    C_NONE,   '0,       1'b0);
         5'd1:    w = mk_uword(U_LEAP,   C_NONE,   '0,       1'b0);
         5'd2:    w = mk_uword(U_MQN,    C_NONE,   '0,       1'b0);
         5'd3:    w = mk_uword(U_DBY,    C_NONE,   '0,       1'b0);
         5'd4:    w = mk_uword(U_ACC1,   C_NONE,   '0,       1'b0);
         5'd5:    w = mk_uword(U_LDY2,   C_OP0,    A_ADDOFF, 1'b0);
         5'd6:    w = mk_uword(U_MQY,    C_NONE,   '0,       1'b0);
         5'd7:    w = mk_uword(U_LEAP,   C_NONE,   '0,       1'b0);
         5'd8:    w = mk_uword(U_MQN,    C_NONE,   '0,       1'b0);
         5'd9:    w = mk_uword(U_DBY,    C_NONE,   '0,       1'b0);
         5'd10:   w = mk_uword(U_ACC2,   C_ALWAYS, A_SINIT,  1'b0);
         5'd11:   w = mk_uword(U_ADDOFF, C_NONE,   '0,       1'b0);
         5'd12:   w = mk_uword(U_SINIT,  C_ZERO,   A_ZERO,   1'b0);
         5'd13:   w = mk_uword(U_MQN,    C_NONE,   '0,       1'b0);
         5'd14:   w = mk_uword(U_DBY,    C_NONE,   '0,       1'b0);
         5'd15:   w = mk_uword(U_SCMP,   C_BIT,    A_SLOOP,  1'b0);
         5'd16:   w = mk_uword(U_MQY,    C_NONE,   '0,       1'b0);
         5'd17:   w = mk_uword(U_LEAP,   C_NONE,   '0,       1'b0);
         5'd18:   w = mk_uword(U_MQN,    C_NONE,   '0,       1'b0);
         5'd19:   w = mk_uword(U_DBY,    C_NONE,   '0,       1'b0);
         5'd20:   w = mk_uword(U_REM,    C_NONE,   '0,       1'b0);
         5'd21:   w = mk_uword(U_WALK,   C_WALK,   A_WALK,   1'b0);
         5'd22:   w = mk_uword(U_DONE,   C_NONE,   '0,       1'b1);
         5'd23:   w = mk_uword(U_ZERO,   C_NONE,   '0,       1'b1);
         default: w = mk_uword(U_ZERO,   C_NONE,   '0,       1'b1);
      endcase
      return w;
   endfunction

   // Days in whole non-leap months before month index k (0 = January)
   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] k);
      logic [DOY_W-1:0] n;
      unique case (k)
         4'd0:    n = 9'd0;
         4'd1:    n = 9'd31;
         4'd2:    n = 9'd59;
         4'd3:    n = 9'd90;
         4'd4:    n = 9'd120;
         4'd5:    n = 9'd151;
         4'd6:    n = 9'd181;
         4'd7:    n = 9'd212;
         4'd8:    n = 9'd243;
         4'd9:    n = 9'd273;
         4'd10:   n = 9'd304;
         4'd11:   n = 9'd334;
         default: n = 9'd365;
      endcase
      return n;
   endfunction

   // Length of month index k (0 = January)
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] k,
                                                   input logic leap);
      logic [DAY_W-1:0] n;
      unique case (k)
         4'd1:                       n = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:    n = 5'd30;
         default:                    n = 5'd31;
      endcase
      return n + DAY_W'(leap && (k == FEB));
   endfunction

   // Ordinal day: whole months before (clipped to the year) plus the day number
   function automatic logic [DOY_W-1:0] ordinal_days(input logic [DAY_W-1:0] d,
                                                      input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [MONTH_W-1:0] whole;
      if (m == '0) begin
         whole = '0;
      end else if (m > MONTH_W'(MONTHS + 1)) begin
         whole = MONTH_W'(MONTHS);
      end else begin
         whole = m - MONTH_W'(1);
      end
      return cum_days(whole) + DOY_W'(leap && (whole > FEB)) + DOY_W'(d);
   endfunction

endpackage

`default_nettype wire

@@ design/ddoa_req_if.sv @@
// ddoa_req_if: request channel (valid/ready plus the two dates and the offset).
// Depends on ddoa_pkg for field widths.
`default_nettype none

interface ddoa_req_if;
   import ddoa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [DAY_W-1:0]       day;
   logic [MONTH_W-1:0]     month;
   logic [YEAR_W-1:0]      year;
   logic [DAY_W-1:0]       other_day;
   logic [MONTH_W-1:0]     other_month;
   logic [YEAR_W-1:0]      other_year;
   logic [OFFSET_BITS-1:0] offset_days;

   modport source (output valid, op, day, month, year, other_day, other_month,
                   other_year, offset_days, input ready);
   modport sink   (input valid, op, day, month, year, other_day, other_month,
                   other_year, offset_days, output ready);
endinterface

`default_nettype wire

@@ design/ddoa_rsp_if.sv @@
// ddoa_rsp_if: response channel (valid/ready plus the resulting date and flags).
// Depends on ddoa_pkg for field widths.
`default_nettype none

interface ddoa_rsp_if;
   import ddoa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [DAY_W-1:0]      res_day;
   logic [MONTH_W-1:0]    res_month;
   logic [RES_YEAR_W-1:0] res_year;
   logic [DOY_W-1:0]      day_of_year;
   logic                  same_date;

   modport source (output valid, res_day, res_month, res_year, day_of_year, same_date,
                   input ready);
   modport sink   (input valid, res_day, res_month, res_year, day_of_year, same_date,
                   output ready);
endinterface

`default_nettype wire

@@ design/date_day_offset_adder.sv @@
// Bulk of the work: year search, 15 passes of 3 microcode steps through the shared
// divide-by-100 multiplier, plus a month walk of 1 to 12 steps; a zero serial skips
// both. One request is worked on at a time: the next request beat is taken once the
// sequencer is done, even while the response register still holds an untaken beat.
// Reset: synchronous, active high; clears the sequencer and the response valid.
`default_nettype none

module date_day_offset_adder (
   input  logic       clock,
   input  logic       reset,
   ddoa_req_if.sink   req,
   ddoa_rsp_if.source rsp
);
   import ddoa_pkg::*;

   // Sequencer control
   logic              busy_ff, busy_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   uword_type         uw;
   logic              accept, out_free, stall, jump;

   // Captured request
   logic                   op_ff, op_in;
   logic [DAY_W-1:0]       d1_ff, d1_in, d2_ff, d2_in;
   logic [MONTH_W-1:0]     m1_ff, m1_in, m2_ff, m2_in;
   logic [YEAR_W-1:0]      y2_ff, y2_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic                   same_ff, same_in;
   logic [YEAR_W-1:0]      y1_clamp, y2_clamp;

   // Datapath
   logic [RES_YEAR_W-1:0] yop_ff, yop_in, yop_m1, mul_x;
   logic [QUO_W-1:0]      q_ff, q_in, q_calc;
   logic [PROD_W-1:0]     mul_p;
   logic [HUND_W-1:0]     hund;
   logic                  leap_ff, leap_in, leap_calc;
   logic [SER_W-1:0]      dby_ff, dby_in, dby_calc;
   logic [SER_W-1:0]      num_ff, num_in;
   logic [DOY_W-1:0]      doy_ff, doy_in, ord1, ord2;
   logic [RES_YEAR_W-1:0] lo_ff, lo_in, new_lo;
   logic [BIT_W-1:0]      bit_ff, bit_in, bit_m1;
   logic                  take;
   logic [DOY_W-1:0]      rem_ff, rem_in;
   logic [MONTH_W-1:0]    mon_ff, mon_in;
   logic [DAY_W-1:0]      mlen;
   logic                  walk_go;

   // Response register
   logic [DAY_W-1:0]      res_day_ff, res_day_in;
   logic [MONTH_W-1:0]    res_month_ff, res_month_in;
   logic [RES_YEAR_W-1:0] res_year_ff, res_year_in;
   logic [DOY_W-1:0]      res_doy_ff, res_doy_in;
   logic                  res_same_ff, res_same_in;

   assign req.ready       = !busy_ff;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.res_day     = res_day_ff;
   assign rsp.res_month   = res_month_ff;
   assign rsp.res_year    = res_year_ff;
   assign rsp.day_of_year = res_doy_ff;
   assign rsp.same_date   = res_same_ff;

   always_comb begin
      uw       = ucode_rom(pc_ff);
      accept   = req.valid && !busy_ff;
      out_free = !rsp_valid_ff || rsp.ready;
      stall    = uw.last && !out_free;

      // Year clamp on the way in
      y1_clamp = (req.year > YEAR_LIMIT) ? YEAR_LIMIT : req.year;
      y2_clamp = (req.other_year > YEAR_LIMIT) ? YEAR_LIMIT : req.other_year;

      // Shared divide-by-100 (reciprocal multiply)
      yop_m1 = yop_ff - RES_YEAR_W'(1);
      mul_x  = (uw.uop == U_MQN) ? yop_m1 : yop_ff;
      mul_p  = PROD_W'(mul_x) * PROD_W'(RECIP_100);
      q_calc = mul_p[PROD_W-1:RECIP_SHIFT];

      // Leap test from yop and q = yop / 100
      hund      = HUND_W'(q_ff) * CENTURY;
      leap_calc = (yop_ff != '0) && (yop_ff[1:0] == 2'b00)
                  && ((HUND_W'(yop_ff) != hund) || (q_ff[1:0] == 2'b00));

      // Days before year, q = (yop - 1) / 100
      if (yop_ff == '0) begin
         dby_calc = '0;
      end else begin
         dby_calc = SER_W'(yop_ff) * DAYS_PER_YEAR + SER_W'(yop_m1 >> 2)
                    - SER_W'(q_ff) + SER_W'(q_ff >> 2);
      end

      ord1 = ordinal_days(d1_ff, m1_ff, leap_ff);
      ord2 = ordinal_days(d2_ff, m2_ff, leap_ff);

      // Year search and month walk
      take    = dby_ff < num_ff;
      new_lo  = take ? yop_ff : lo_ff;
      bit_m1  = bit_ff - BIT_W'(1);
      mlen    = month_len(mon_ff, leap_ff);
      walk_go = (mon_ff < MONTH_W'(MONTHS - 1)) && (rem_ff > DOY_W'(mlen));

      // Jump condition
      unique case (uw.cond)
         C_NONE:   jump = 1'b0;
         C_ALWAYS: jump = 1'b1;
         C_OP0:    jump = !op_ff;
         C_ZERO:   jump = (num_ff == '0);
         C_BIT:    jump = (bit_ff != '0);
         C_WALK:   jump = walk_go;
         default:  jump = 1'b0;
      endcase

      // Hold by default
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      op_in   = op_ff;   d1_in = d1_ff; m1_in = m1_ff; d2_in = d2_ff; m2_in = m2_ff;
      y2_in   = y2_ff;   off_in = off_ff; same_in = same_ff;
      yop_in  = yop_ff;  q_in = q_ff;   leap_in = leap_ff; dby_in = dby_ff;
      num_in  = num_ff;  doy_in = doy_ff; lo_in = lo_ff; bit_in = bit_ff;
      rem_in  = rem_ff;  mon_in = mon_ff;
      res_day_in   = res_day_ff;
      res_month_in = res_month_ff;
      res_year_in  = res_year_ff;
      res_doy_in   = res_doy_ff;
      res_same_in  = res_same_ff;

      // Request beat: capture and start the program
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = '0;
         op_in   = req.op;
         d1_in   = req.day;
         m1_in   = req.month;
         d2_in   = req.other_day;
         m2_in   = req.other_month;
         y2_in   = y2_clamp;
         off_in  = req.offset_days;
         yop_in  = RES_YEAR_W'(y1_clamp);
         same_in = (req.day == req.other_day) && (req.month == req.other_month)
                   && (req.year == req.other_year);
      end

      // Execute one control word
      if (busy_ff && !stall) begin
         if (uw.last) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            pc_in = jump ? uw.target : pc_ff + PC_W'(1);
         end

         unique case (uw.uop)
            U_MQY, U_MQN: q_in = q_calc;
            U_LEAP:       leap_in = leap_calc;
            U_DBY:        dby_in = dby_calc;
            U_ACC1: begin
               num_in = dby_ff + SER_W'(ord1);
               doy_in = ord1;
            end
            U_LDY2:       yop_in = RES_YEAR_W'(y2_ff);
            U_ACC2:       num_in = num_ff + dby_ff + SER_W'(ord2);
            U_ADDOFF:     num_in = num_ff + SER_W'(off_ff);
            U_SINIT: begin
               lo_in  = '0;
               bit_in = BIT_W'(RES_YEAR_W - 1);
               yop_in = RES_YEAR_W'(1) << (RES_YEAR_W - 1);
            end
            U_SCMP: begin
               lo_in = new_lo;
               if (bit_ff != '0) begin
                  bit_in = bit_m1;
                  yop_in = new_lo | (RES_YEAR_W'(1) << bit_m1);
               end else begin
                  yop_in = new_lo;
               end
            end
            U_REM: begin
               rem_in = DOY_W'(num_ff - dby_ff);
               mon_in = '0;
            end
            U_WALK: begin
               if (walk_go) begin
                  rem_in = rem_ff - DOY_W'(mlen);
                  mon_in = mon_ff + MONTH_W'(1);
               end
            end
            U_DONE: begin
               res_day_in   = rem_ff[DAY_W-1:0];
               res_month_in = mon_ff + MONTH_W'(1);
               res_year_in  = lo_ff;
               res_doy_in   = doy_ff;
               res_same_in  = same_ff;
            end
            U_ZERO: begin
               res_day_in   = LAST_DAY;
               res_month_in = LAST_MONTH;
               res_year_in  = '0;
               res_doy_in   = doy_ff;
               res_same_in  = same_ff;
            end
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      d1_ff        <= d1_in;
      m1_ff        <= m1_in;
      d2_ff        <= d2_in;
      m2_ff        <= m2_in;
      y2_ff        <= y2_in;
      off_ff       <= off_in;
      same_ff      <= same_in;
      yop_ff       <= yop_in;
      q_ff         <= q_in;
      leap_ff      <= leap_in;
      dby_ff       <= dby_in;
      num_ff       <= num_in;
      doy_ff       <= doy_in;
      lo_ff        <= lo_in;
      bit_ff       <= bit_in;
      rem_ff       <= rem_in;
      mon_ff       <= mon_in;
      res_day_ff   <= res_day_in;
      res_month_ff <= res_month_in;
      res_year_ff  <= res_year_in;
      res_doy_ff   <= res_doy_in;
      res_same_ff  <= res_same_in;
   end

endmodule

`default_nettype wire

@@ design/ddoa_checker.sv @@
// ddoa_checker: port-level assertions for date_day_offset_adder, plus its bind.
// Depends on ddoa_pkg for widths and calendar constants.
`default_nettype none

module ddoa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ddoa_pkg::MONTH_W-1:0]    rsp_res_month,
   input logic [ddoa_pkg::RES_YEAR_W-1:0] rsp_res_year
);
   import ddoa_pkg::*;

   // Reset empties the response register
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One item at a time: request side closes after a beat
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while sequencer busy");

   // A fresh response coincides with the sequencer going idle
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response appeared while sequencer still busy");

   // Result month is a real month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_res_month >= MONTH_W'(1) && rsp_res_month <= LAST_MONTH))
      else $error("result month out of range");

   // Stalled response beat stays valid and keeps its year
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_res_year)))
      else $error("stalled response changed");

endmodule

bind date_day_offset_adder ddoa_checker u_ddoa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_res_month (rsp.res_month),
   .rsp_res_year  (rsp.res_year)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for date_day_offset_adder (date plus offset, date plus date).
// Depends on ddoa_pkg, the ddoa_req_if / ddoa_rsp_if channels and the adder RTL.

module testbench;
   import ddoa_pkg::*;

   localparam int   CLK_HALF       = 10;
   localparam int   RESET_CYCLES   = 2;
   localparam int   RANDOM_ITEMS   = 700;
   localparam int   WATCHDOG_LIMIT = 4000;
   localparam int   DRAIN_CYCLES   = 150;
   localparam int   MAX_REPORTS    = 10;
   localparam int   MAX_OFFSET     = (1 << OFFSET_BITS) - 1;
   localparam int   MAX_RAW_YEAR   = (1 << YEAR_W) - 1;
   localparam logic OP_ADD_OFFSET  = 1'b0;
   localparam logic OP_ADD_DATE    = 1'b1;

   typedef struct packed {
      logic                   op;
      logic [DAY_W-1:0]       day;
      logic [MONTH_W-1:0]     month;
      logic [YEAR_W-1:0]      year;
      logic [DAY_W-1:0]       other_day;
      logic [MONTH_W-1:0]     other_month;
      logic [YEAR_W-1:0]      other_year;
      logic [OFFSET_BITS-1:0] offset_days;
   } date_req_type;

   typedef struct packed {
      logic [DAY_W-1:0]      res_day;
      logic [MONTH_W-1:0]    res_month;
      logic [RES_YEAR_W-1:0] res_year;
      logic [DOY_W-1:0]      day_of_year;
      logic                  same_date;
   } date_rsp_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         drv_valid  = 1'b0;
   date_req_type drv_req    = '0;
   logic         sink_ready = 1'b0;

   date_req_type pending_reqs[$];
   date_rsp_type expected_dates[$];

   int gap_left      = 0;
   int stall_left    = 0;
   int idle_cycles   = 0;
   int reqs_taken    = 0;
   int date_sums     = 0;
   int dates_checked = 0;
   int fail_count    = 0;
   int directed_reqs = 0;

   ddoa_req_if req_bus();
   ddoa_rsp_if rsp_bus();

   assign req_bus.valid       = drv_valid;
   assign req_bus.op          = drv_req.op;
   assign req_bus.day         = drv_req.day;
   assign req_bus.month       = drv_req.month;
   assign req_bus.year        = drv_req.year;
   assign req_bus.other_day   = drv_req.other_day;
   assign req_bus.other_month = drv_req.other_month;
   assign req_bus.other_year  = drv_req.other_year;
   assign req_bus.offset_days = drv_req.offset_days;
   assign rsp_bus.ready       = sink_ready;

   date_day_offset_adder uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // ---------------------------------------------------------------- calendar predictor
   function automatic bit leap_year(input int unsigned y);
      if (y == 0) return 1'b0;
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4 == 0);
   endfunction

   // k is a month index, 0 = January
   function automatic int unsigned days_in_month(input int unsigned k, input int unsigned y);
      int unsigned n;
      case (k)
         1:           n = 28;
         3, 5, 8, 10: n = 30;
         default:     n = 31;
      endcase
      if (k == 1 && leap_year(y)) n++;
      return n;
   endfunction

   function automatic longint unsigned days_before_year(input longint unsigned y);
      longint unsigned n;
      if (y == 0) return 0;
      n = y - 1;
      return 365 * y + n / 4 - n / 100 + n / 400;
   endfunction

   // whole months before the day, clipped to one year, plus the day as given
   function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
      int unsigned whole, sum;
      whole = (m == 0) ? 0 : m - 1;
      if (whole > 12) whole = 12;
      sum = 0;
      for (int unsigned k = 0; k < whole; k++) sum += days_in_month(k, y);
      return sum + d;
   endfunction

   function automatic longint unsigned serial_day(input int unsigned d, input int unsigned m,
                                                  input int unsigned y);
      return days_before_year(y) + ordinal_day(d, m, y);
   endfunction

   function automatic date_rsp_type predict_date_sum(input date_req_type r);
      date_rsp_type    o;
      int unsigned     y1, y2, mon;
      longint unsigned total, lo, hi, mid, rem;
      // years past the limit saturate for arithmetic only
      y1 = (r.year > YEAR_LIMIT) ? YEAR_LIMIT : r.year;
      y2 = (r.other_year > YEAR_LIMIT) ? YEAR_LIMIT : r.other_year;
      total = serial_day(r.day, r.month, y1);
      if (r.op == OP_ADD_DATE) total += serial_day(r.other_day, r.other_month, y2);
      else total += r.offset_days;
      if (total == 0) begin
         // only reachable with day zero in month 0 or 1 of year 0 and nothing added to it
         o.res_day   = LAST_DAY;
         o.res_month = LAST_MONTH;
         o.res_year  = '0;
      end else begin
         // largest year whose start lies before the serial
         lo = 0;
         hi = 64'd1 << 24;
         while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (days_before_year(mid) < total) lo = mid;
            else hi = mid;
         end
         rem = total - days_before_year(lo);
         mon = 0;
         while (mon < 11 && rem > days_in_month(mon, int'(lo))) begin
            rem -= days_in_month(mon, int'(lo));
            mon++;
         end
         o.res_day   = DAY_W'(rem);
         o.res_month = MONTH_W'(mon + 1);
         o.res_year  = RES_YEAR_W'(lo);
      end
      o.day_of_year = DOY_W'(ordinal_day(r.day, r.month, y1));
      o.same_date   = (r.day == r.other_day) && (r.month == r.other_month) &&
                      (r.year == r.other_year);
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   task automatic queue_req(input logic op, input int unsigned d, m, y, od, om, oy, off);
      date_req_type r;
      r.op          = op;
      r.day         = DAY_W'(d);
      r.month       = MONTH_W'(m);
      r.year        = YEAR_W'(y);
      r.other_day   = DAY_W'(od);
      r.other_month = MONTH_W'(om);
      r.other_year  = YEAR_W'(oy);
      r.offset_days = OFFSET_BITS'(off);
      pending_reqs.push_back(r);
   endtask

   // well-formed date, biased toward leap, century and range edges
   task automatic pick_date(output int unsigned d, m, y);
      int unsigned len;
      if ($urandom_range(0, 9) < 7) begin
         y = $urandom_range(0, YEAR_LIMIT);
      end else begin
         case ($urandom_range(0, 3))
            0:       y = $urandom_range(0, 4);
            1:       y = $urandom_range(YEAR_LIMIT - 4, YEAR_LIMIT);
            2:       y = $urandom_range(0, 99) * 100;
            default: y = $urandom_range(0, 2499) * 4;
         endcase
      end
      m   = $urandom_range(1, 12);
      len = days_in_month(m - 1, y);
      case ($urandom_range(0, 9))
         0:       d = len;
         1:       d = 1;
         default: d = $urandom_range(1, len);
      endcase
   endtask

   // idle length for either side; every fourth stretch of 48 beats runs flat out
   function automatic int pick_idle(input int beats);
      int r;
      if ((beats / 48) % 4 == 3) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 4);
      if (r < 97) return $urandom_range(5, 24);
      return $urandom_range(40, 160);
   endfunction

   // ---------------------------------------------------------------- request driver
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (drv_valid && req_bus.ready) begin
            expected_dates.push_back(predict_date_sum(drv_req));
            reqs_taken++;
            if (drv_req.op == OP_ADD_DATE) date_sums++;
         end
         if (!drv_valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               drv_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               drv_req   <= pending_reqs.pop_front();
               drv_valid <= 1'b1;
               gap_left  <= pick_idle(reqs_taken);
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(posedge clock) begin : result_check
      date_rsp_type want, got;
      int           hold;
      bit           bad;
      if (reset) begin
         sink_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         hold = stall_left;
         if (rsp_bus.valid && sink_ready) begin
            got.res_day     = rsp_bus.res_day;
            got.res_month   = rsp_bus.res_month;
            got.res_year    = rsp_bus.res_year;
            got.day_of_year = rsp_bus.day_of_year;
            got.same_date   = rsp_bus.same_date;
            if (expected_dates.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected result beat %0d/%0d/%0d doy %0d same %0d",
                           got.res_day, got.res_month, got.res_year,
                           got.day_of_year, got.same_date);
            end else begin
               want = expected_dates.pop_front();
               bad  = (got.res_day !== want.res_day) || (got.res_month !== want.res_month) ||
                      (got.res_year !== want.res_year) ||
                      (got.day_of_year !== want.day_of_year) ||
                      (got.same_date !== want.same_date);
               if (bad) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("result %0d: expected %0d/%0d/%0d doy %0d same %0d, got %0d/%0d/%0d doy %0d same %0d",
                              dates_checked, want.res_day, want.res_month, want.res_year,
                              want.day_of_year, want.same_date, got.res_day, got.res_month,
                              got.res_year, got.day_of_year, got.same_date);
               end
            end
            dates_checked++;
            hold = pick_idle(dates_checked);
         end else if (hold == 0 && $urandom_range(0, 19) == 0) begin
            // occasional stall that is not tied to a beat
            hold = pick_idle(dates_checked);
         end
         if (hold != 0) begin
            sink_ready <= 1'b0;
            stall_left <= hold - 1;
         end else begin
            sink_ready <= 1'b1;
            stall_left <= 0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (drv_valid && req_bus.ready) || (rsp_bus.valid && sink_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run
   initial begin : stimulus
      int unsigned d, m, y, od, om, oy, off;
      int          kind;
      logic        op;

      // directed: first and zero serial, maxima, saturation, odd months and days, leap edges
      queue_req(OP_ADD_OFFSET, 1, 1, 0, 2, 1, 0, 0);
      queue_req(OP_ADD_OFFSET, 0, 0, 0, 1, 1, 1, 0);
      queue_req(OP_ADD_DATE, 0, 1, 0, 0, 0, 0, 0);
      queue_req(OP_ADD_OFFSET, 31, 12, YEAR_LIMIT, 1, 1, 1, MAX_OFFSET);
      queue_req(OP_ADD_DATE, 31, 12, YEAR_LIMIT, 31, 12, YEAR_LIMIT, 0);
      queue_req(OP_ADD_DATE, 31, 12, YEAR_LIMIT - 1, 1, 1, 0, 0);
      queue_req(OP_ADD_DATE, 15, 6, MAX_RAW_YEAR, 15, 6, MAX_RAW_YEAR, 0);
      queue_req(OP_ADD_DATE, 15, 6, YEAR_LIMIT + 1, 15, 6, YEAR_LIMIT, 12345);
      queue_req(OP_ADD_OFFSET, 1, 3, 12000, 1, 3, 12001, 1000);
      queue_req(OP_ADD_OFFSET, 10, 0, 2001, 10, 1, 2001, 5);
      queue_req(OP_ADD_OFFSET, 10, 13, 2004, 9, 13, 2004, 5);
      queue_req(OP_ADD_DATE, 3, 15, 1999, 4, 14, 2000, 0);
      queue_req(OP_ADD_OFFSET, 0, 5, 1777, 1, 5, 1777, 0);
      queue_req(OP_ADD_OFFSET, 31, 2, 2000, 30, 2, 2000, 0);
      queue_req(OP_ADD_DATE, 31, 15, 2000, 31, 15, 2000, 0);
      queue_req(OP_ADD_OFFSET, 28, 2, 1900, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 28, 2, 2000, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 29, 2, 2004, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 28, 2, 0, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 31, 12, 1999, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 31, 12, 0, 1, 1, 1, 1);
      queue_req(OP_ADD_OFFSET, 7, 7, 7777, 8, 8, 8888, 20'hAAAAA);
      queue_req(OP_ADD_OFFSET, 21, 9, 1234, 22, 10, 4321, 20'h55555);
      queue_req(OP_ADD_DATE, 29, 2, 2000, 29, 2, 2000, 0);
      queue_req(OP_ADD_OFFSET, 5, 5, 2020, 5, 5, 2020, 100);
      directed_reqs = pending_reqs.size();

      // random: mostly well-formed dates, some saturated years, some raw noise
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = $urandom_range(0, 99);
         op   = 1'($urandom_range(0, 1));
         if (kind < 8) begin
            queue_req(op, $urandom_range(0, 31), $urandom_range(0, 15),
                      $urandom_range(0, MAX_RAW_YEAR), $urandom_range(0, 31),
                      $urandom_range(0, 15), $urandom_range(0, MAX_RAW_YEAR),
                      $urandom_range(0, MAX_OFFSET));
         end else begin
            pick_date(d, m, y);
            if (kind < 14) y = $urandom_range(YEAR_LIMIT + 1, MAX_RAW_YEAR);
            if ($urandom_range(0, 7) == 0) begin
               od = d;
               om = m;
               oy = y;
            end else begin
               pick_date(od, om, oy);
            end
            case ($urandom_range(0, 3))
               0:       off = $urandom_range(0, 400);
               1:       off = $urandom_range(0, 40000);
               default: off = $urandom_range(0, MAX_OFFSET);
            endcase
            queue_req(op, d, m, y, od, om, oy, off);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sample on the falling edge so driver updates have settled
      while (pending_reqs.size() != 0 || drv_valid) @(negedge clock);
      while (expected_dates.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_dates.size() != 0) begin
         $display("%0d expected results never arrived", expected_dates.size());
         fail_count += expected_dates.size();
      end

      $display("covered %0d requests (%0d directed), %0d date sums and %0d offset sums",
               reqs_taken, directed_reqs, date_sums, reqs_taken - date_sums);
      $display("checked %0d result beats, %0d failures", dates_checked, fail_count);
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
